FILE: hw/rtl/ilc_pkg.sv
// ----------------------------------------------------------------------------
// Linear classifier package
// Shared types, codes and constants of the integer linear classifier.
// ----------------------------------------------------------------------------
package ilc_pkg;

    localparam int DEFAULT_MAX_FEATURES = 16;
    localparam int DEFAULT_MAX_CLASSES  = 8;

    localparam int SCORE_W     = 32;
    localparam int POS_W       = 5;
    localparam int FEAT_CNT_W  = 5;
    localparam int CLASS_CNT_W = 4;
    localparam int BASE_W      = 8;
    localparam int COEFF_W     = 8;
    localparam int FEATURE_W   = 24;
    localparam int SLOT_W      = 7;
    localparam int CLASS_ID_W  = 3;
    localparam int CONF_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int DIV_SHIFT   = 5;
    localparam int CONF_OFFSET = 40;
    localparam int CONF_MAX    = 100;
    localparam int CONF_HI     = CONF_MAX / 2 - CONF_OFFSET;
    localparam int CONF_LO     = -CONF_OFFSET;

    localparam logic [POS_W-1:0]       POS_LIMIT           = 5'd31;
    localparam logic [FEAT_CNT_W-1:0]  RESET_FEATURE_COUNT = 5'd16;
    localparam logic [CLASS_CNT_W-1:0] RESET_CLASS_COUNT   = 4'd4;
    localparam logic [BASE_W-1:0]      RESET_STATE_BASE    = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_BASE    = 2'd2;

    typedef enum logic [1:0] {
        KIND_WEIGHT    = 2'd0,
        KIND_BIAS      = 2'd1,
        KIND_FEATURE   = 2'd2,
        KIND_NOT_READY = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic [SLOT_W-1:0]            slot;
        logic signed [COEFF_W-1:0]    coeff;
        logic signed [FEATURE_W-1:0]  feature_value;
        logic                         last_feature;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_ID_W-1:0] class_id;
        logic [BASE_W-1:0]     state_code;
        logic [CONF_W-1:0]     confidence;
    } t_out_item;

    typedef struct packed {
        logic                      weight_we;
        logic                      bias_we;
        logic [SLOT_W-1:0]         slot;
        logic signed [COEFF_W-1:0] coeff;
    } t_coef_wr;

    typedef struct packed {
        logic issue;
        logic start;
        logic acc_en;
        logic scored;
        logic tail;
        logic clear;
    } t_lane_ctl;

endpackage

FILE: hw/rtl/int8_linear_classifier.sv
// ----------------------------------------------------------------------------
// Integer linear classifier with argmax
// Signed 8-bit weights and biases scored against 24-bit features; reports the
// best class, its state code and a clamped confidence.
// ----------------------------------------------------------------------------
// A weight or bias load is written straight to its memory and leaves the
// block idle for the next transfer. A feature transfer reads the score
// memory, multiplies, accumulates and writes back for one class per cycle
// through a four-stage pipeline, which then drains before the next transfer.
// The feature that ends a vector hands its result through the finish state
// to the output register, as does a not-ready transfer, and waits while the
// output stalls. Loads are taken while an earlier result still waits there.
module int8_linear_classifier import ilc_pkg::*; #(
    parameter int MAX_FEATURES = DEFAULT_MAX_FEATURES,
    parameter int MAX_CLASSES  = DEFAULT_MAX_CLASSES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam int CLS_W = $clog2(MAX_CLASSES);
    localparam logic [CLS_W-1:0] CLS_LAST = CLS_W'(MAX_CLASSES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WAIT,
        ST_FINISH
    } t_state;

    logic [FEAT_CNT_W-1:0]  r_feature_count;
    logic [CLASS_CNT_W-1:0] r_class_count;
    logic [BASE_W-1:0]      r_state_base;

    t_state                      r_state, n_state;
    logic [CLS_W-1:0]            r_cls, n_cls;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic                        r_acc, n_acc;
    logic                        r_last, n_last;
    logic signed [FEATURE_W-1:0] r_fv, n_fv;
    t_out_item                   r_res, n_res;
    logic                        r_out_valid, n_out_valid;
    t_out_item                   r_out_data, n_out_data;

    logic                      in_accept;
    logic                      out_free;
    t_coef_wr                  coef_wr;
    t_lane_ctl                 lane_ctl;
    logic [POS_W-1:0]          rd_pos;
    logic signed [COEFF_W-1:0] weight;
    logic signed [COEFF_W-1:0] bias;
    logic                      done;
    logic                      found;
    logic [SCORE_W-1:0]        best;
    logic [CLS_W-1:0]          best_cls;
    logic [BASE_W-1:0]         best_cls8;
    logic [CONF_W-1:0]         best_low;
    logic [CONF_W-1:0]         conf_sum;
    logic [CONF_W-1:0]         conf;
    logic                      pos_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= RESET_FEATURE_COUNT;
            r_class_count   <= RESET_CLASS_COUNT;
            r_state_base    <= RESET_STATE_BASE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FEATURE_COUNT: r_feature_count <= i_cfg_wdata[FEAT_CNT_W-1:0];
                CFG_CLASS_COUNT:   r_class_count   <= i_cfg_wdata[CLASS_CNT_W-1:0];
                CFG_STATE_BASE:    r_state_base    <= i_cfg_wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign pos_in_range = (r_pos < r_feature_count) && (32'(r_pos) < 32'(MAX_FEATURES));

    assign coef_wr.weight_we = in_accept && (i_in_data.kind == KIND_WEIGHT);
    assign coef_wr.bias_we   = in_accept && (i_in_data.kind == KIND_BIAS);
    assign coef_wr.slot      = i_in_data.slot;
    assign coef_wr.coeff     = i_in_data.coeff;

    assign rd_pos = r_acc ? r_pos : '0;

    assign lane_ctl.issue  = (r_state == ST_SWEEP);
    assign lane_ctl.start  = (r_cls == '0);
    assign lane_ctl.acc_en = r_acc;
    assign lane_ctl.scored = 32'(r_cls) < 32'(r_class_count);
    assign lane_ctl.tail   = (r_cls == CLS_LAST);
    assign lane_ctl.clear  = ((r_state == ST_WAIT) && done && r_last) ||
                             (in_accept && (i_in_data.kind == KIND_NOT_READY));

    ilc_coef_store #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_CLASSES  (MAX_CLASSES)
    ) u_coef_store (
        .i_clk    (i_clk),
        .i_wr     (coef_wr),
        .i_rd_en  (lane_ctl.issue),
        .i_rd_cls (r_cls),
        .i_rd_pos (rd_pos),
        .o_weight (weight),
        .o_bias   (bias)
    );

    ilc_score_unit #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_score_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_cls      (r_cls),
        .i_feature  (r_fv),
        .i_weight   (weight),
        .i_bias     (bias),
        .o_done     (done),
        .o_found    (found),
        .o_best     (best),
        .o_best_cls (best_cls)
    );

    assign best_cls8 = BASE_W'(best_cls);
    assign best_low  = best[CONF_W-1:0];
    assign conf_sum  = best_low + CONF_W'(CONF_OFFSET);

    always_comb begin
        if (!found) begin
            conf = '0;
        end else if ($signed(best) >= 32'(CONF_HI)) begin
            conf = CONF_W'(CONF_MAX);
        end else if ($signed(best) <= 32'(CONF_LO)) begin
            conf = '0;
        end else begin
            conf = {conf_sum[CONF_W-2:0], 1'b0};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cls       = r_cls;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_last      = r_last;
        n_fv        = r_fv;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_data.kind)
                        KIND_FEATURE: begin
                            n_fv    = i_in_data.feature_value;
                            n_last  = i_in_data.last_feature;
                            n_acc   = pos_in_range;
                            n_cls   = '0;
                            n_state = ST_SWEEP;
                        end
                        KIND_NOT_READY: begin
                            n_res.class_id   = '0;
                            n_res.state_code = r_state_base;
                            n_res.confidence = '0;
                            n_pos            = '0;
                            n_state          = ST_FINISH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                n_cls = r_cls + 1'b1;
                if (r_cls == CLS_LAST) begin
                    n_cls   = '0;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (done) begin
                    if (r_last) begin
                        n_res.class_id   = found ? best_cls8[CLASS_ID_W-1:0] : '0;
                        n_res.state_code = r_state_base + (found ? best_cls8 : '0);
                        n_res.confidence = conf;
                        n_pos            = '0;
                        n_state          = ST_FINISH;
                    end else begin
                        n_pos   = (r_pos == POS_LIMIT) ? r_pos : r_pos + 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cls       <= '0;
            r_pos       <= '0;
            r_acc       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cls       <= n_cls;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_fv       <= n_fv;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/ilc_coef_store.sv
// ----------------------------------------------------------------------------
// Coefficient store
// Weight and bias memories with one write port for load transfers and one
// synchronous read port addressed by class and feature position.
// ----------------------------------------------------------------------------
module ilc_coef_store import ilc_pkg::*; #(
    parameter int MAX_FEATURES = DEFAULT_MAX_FEATURES,
    parameter int MAX_CLASSES  = DEFAULT_MAX_CLASSES
) (
    input  logic                      i_clk,
    input  t_coef_wr                  i_wr,
    input  logic                      i_rd_en,
    input  logic [$clog2(MAX_CLASSES)-1:0] i_rd_cls,
    input  logic [POS_W-1:0]          i_rd_pos,
    output logic signed [COEFF_W-1:0] o_weight,
    output logic signed [COEFF_W-1:0] o_bias
);

    localparam int CLS_W   = $clog2(MAX_CLASSES);
    localparam int WDEPTH  = MAX_CLASSES * MAX_FEATURES;
    localparam int WADDR_W = $clog2(WDEPTH);

    logic signed [COEFF_W-1:0] r_weight_mem [WDEPTH];
    logic signed [COEFF_W-1:0] r_bias_mem   [MAX_CLASSES];
    logic signed [COEFF_W-1:0] r_weight;
    logic signed [COEFF_W-1:0] r_bias;

    logic [31:0]        slot_ext;
    logic [31:0]        rd_full;
    logic [WADDR_W-1:0] wr_waddr;
    logic [WADDR_W-1:0] rd_waddr;
    logic [CLS_W-1:0]   wr_baddr;
    logic               weight_ok;
    logic               bias_ok;

    assign slot_ext  = 32'(i_wr.slot);
    assign wr_waddr  = slot_ext[WADDR_W-1:0];
    assign wr_baddr  = slot_ext[CLS_W-1:0];
    assign weight_ok = slot_ext < 32'(WDEPTH);
    assign bias_ok   = slot_ext < 32'(MAX_CLASSES);
    assign rd_full   = 32'(i_rd_cls) * 32'(MAX_FEATURES) + 32'(i_rd_pos);
    assign rd_waddr  = rd_full[WADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.weight_we && weight_ok) begin
            r_weight_mem[wr_waddr] <= i_wr.coeff;
        end
        if (i_rd_en) begin
            r_weight <= r_weight_mem[rd_waddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.bias_we && bias_ok) begin
            r_bias_mem[wr_baddr] <= i_wr.coeff;
        end
        if (i_rd_en) begin
            r_bias <= r_bias_mem[i_rd_cls];
        end
    end

    assign o_weight = r_weight;
    assign o_bias   = r_bias;

endmodule

FILE: hw/rtl/ilc_score_unit.sv
// ----------------------------------------------------------------------------
// Score unit
// Score memory with per-entry valid bits, a multiply-accumulate
// read-modify-write pipeline and a running argmax over the biased scores.
// ----------------------------------------------------------------------------
module ilc_score_unit import ilc_pkg::*; #(
    parameter int MAX_CLASSES = DEFAULT_MAX_CLASSES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lane_ctl                   i_ctl,
    input  logic [$clog2(MAX_CLASSES)-1:0] i_cls,
    input  logic signed [FEATURE_W-1:0] i_feature,
    input  logic signed [COEFF_W-1:0]   i_weight,
    input  logic signed [COEFF_W-1:0]   i_bias,
    output logic                        o_done,
    output logic                        o_found,
    output logic [SCORE_W-1:0]          o_best,
    output logic [$clog2(MAX_CLASSES)-1:0] o_best_cls
);

    localparam int CLS_W = $clog2(MAX_CLASSES);

    logic [SCORE_W-1:0]     r_score_mem [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] r_score_vld;

    logic                      r_v1, r_v2, r_v3;
    t_lane_ctl                 r_ctl1, r_ctl2, r_ctl3;
    logic [CLS_W-1:0]          r_cls1, r_cls2, r_cls3;
    logic [SCORE_W-1:0]        r_score1;
    logic                      r_hit1;
    logic [SCORE_W-1:0]        r_score2;
    logic signed [SCORE_W-1:0] r_prod2;
    logic signed [COEFF_W-1:0] r_bias2, r_bias3;
    logic [SCORE_W-1:0]        r_new3;
    logic                      r_done;
    logic                      r_found;
    logic [SCORE_W-1:0]        r_best;
    logic [CLS_W-1:0]          r_best_cls;

    logic signed [SCORE_W-1:0] prod;
    logic signed [SCORE_W-1:0] biased;
    logic signed [SCORE_W-1:0] quot;
    logic [SCORE_W-1:0]        new_score;
    logic [SCORE_W-1:0]        sum;
    logic                      take;

    assign prod      = 32'(i_weight) * 32'(i_feature);
    assign biased    = r_prod2 + (r_prod2[SCORE_W-1] ? 32'sd31 : 32'sd0);
    assign quot      = biased >>> DIV_SHIFT;
    assign new_score = r_score2 + (r_ctl2.acc_en ? SCORE_W'(quot) : '0);
    assign sum       = r_new3 + SCORE_W'(r_bias3);
    assign take      = r_v3 && r_ctl3.scored &&
                       (!r_found || ($signed(sum) > $signed(r_best)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_score1 <= r_score_mem[i_cls];
        end
        if (r_v2) begin
            r_score_mem[r_cls2] <= new_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_vld <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_done      <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_score_vld <= '0;
            end else if (r_v2) begin
                r_score_vld[r_cls2] <= 1'b1;
            end
            r_v1   <= i_ctl.issue;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3 && r_ctl3.tail;
            if (i_ctl.issue && i_ctl.start) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl1   <= i_ctl;
        r_cls1   <= i_cls;
        r_hit1   <= r_score_vld[i_cls];
        r_ctl2   <= r_ctl1;
        r_cls2   <= r_cls1;
        r_prod2  <= prod;
        r_score2 <= r_hit1 ? r_score1 : '0;
        r_bias2  <= i_bias;
        r_ctl3   <= r_ctl2;
        r_cls3   <= r_cls2;
        r_new3   <= new_score;
        r_bias3  <= r_bias2;
        if (take) begin
            r_best     <= sum;
            r_best_cls <= r_cls3;
        end
    end

    assign o_done     = r_done;
    assign o_found    = r_found;
    assign o_best     = r_best;
    assign o_best_cls = r_best_cls;

endmodule

FILE: tb/int8_linear_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer linear classifier testbench
// Preloads every weight and bias, then runs a table of directed transfers and
// several phases of random vectors, loads and not-ready transfers under
// different register settings. Both channels idle at random. Every result is
// checked field by field against a predictor of the scoring and argmax, or against the typed-in result.
// ----------------------------------------------------------------------------
module int8_linear_classifier_tb;
    import ilc_pkg::*;

    localparam int N_FEATURES     = DEFAULT_MAX_FEATURES;
    localparam int N_CLASSES      = DEFAULT_MAX_CLASSES;
    localparam int DRAIN_CYCLES   = N_CLASSES + 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int N_PHASES       = 9;
    localparam int N_FIXED_PHASES = 7;
    localparam int PHASE_ITEMS    = 185;
    localparam int MAX_REPORTS    = 40;

    localparam logic [FEAT_CNT_W-1:0]  PHASE_FEATURES [N_FIXED_PHASES] = '{16, 1, 0, 31, 16, 5, 12};
    localparam logic [CLASS_CNT_W-1:0] PHASE_CLASSES  [N_FIXED_PHASES] = '{8, 1, 8, 15, 0, 9, 2};
    localparam logic [BASE_W-1:0]      PHASE_BASES    [N_FIXED_PHASES] = '{0, 255, 128, 7, 200, 1, 254};

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;

    logic signed [COEFF_W-1:0] weight_mem [N_CLASSES*N_FEATURES];
    logic signed [COEFF_W-1:0] bias_mem   [N_CLASSES];
    logic [SCORE_W-1:0]        score_acc  [N_CLASSES];
    logic [POS_W-1:0]          feat_pos;
    logic [FEAT_CNT_W-1:0]     cfg_features;
    logic [CLASS_CNT_W-1:0]    cfg_classes;
    logic [BASE_W-1:0]         cfg_base;

    t_out_item awaited_results [$];
    t_out_item oldest;
    int        error_count;
    int        items_sent;
    int        results_checked;
    int        not_ready_sent;
    int        vectors_closed;
    int        quiet_cycles;
    int        hold_requests;
    int        holds_served;
    bit        calm;

    int8_linear_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    function automatic void clear_scores();
        int c;
        for (c = 0; c < N_CLASSES; c++) begin
            score_acc[c] = '0;
        end
        feat_pos = '0;
    endfunction

    // Updates the predicted state for one accepted transfer and queues the
    // result it causes, or the typed-in result when the row carries one.
    function automatic void score_item(input t_in_item it, input bit typed,
                                       input t_out_item want);
        int                 nf;
        int                 nc;
        int                 c;
        int                 best_class;
        longint             prod;
        longint             cand;
        longint             best;
        longint             conf;
        logic [SCORE_W-1:0] total;
        t_out_item          res;
        nf = (cfg_features > N_FEATURES) ? N_FEATURES : int'(cfg_features);
        nc = (cfg_classes > N_CLASSES) ? N_CLASSES : int'(cfg_classes);
        res = '0;
        best = 0;
        best_class = 0;
        case (it.kind)
            KIND_WEIGHT: begin
                weight_mem[it.slot] = it.coeff;
            end
            KIND_BIAS: begin
                if (it.slot < N_CLASSES) begin
                    bias_mem[it.slot[2:0]] = it.coeff;
                end
            end
            KIND_NOT_READY: begin
                clear_scores();
                res.state_code = cfg_base;
                awaited_results.push_back(typed ? want : res);
            end
            default: begin
                if (feat_pos < nf) begin
                    for (c = 0; c < N_CLASSES; c++) begin
                        prod = longint'(weight_mem[c*N_FEATURES + int'(feat_pos)])
                             * longint'($signed(it.feature_value));
                        score_acc[c] = score_acc[c] + SCORE_W'(prod / (1 << DIV_SHIFT));
                    end
                end
                if (feat_pos != POS_LIMIT) begin
                    feat_pos = feat_pos + 1'b1;
                end
                if (it.last_feature) begin
                    for (c = 0; c < nc; c++) begin
                        total = score_acc[c] + SCORE_W'(longint'(bias_mem[c]));
                        cand = longint'($signed(total));
                        if (c == 0 || cand > best) begin
                            best = cand;
                            best_class = c;
                        end
                    end
                    if (nc == 0) begin
                        conf = 0;
                    end else begin
                        conf = (best + CONF_OFFSET) * 2;
                        if (conf < 0) begin
                            conf = 0;
                        end
                        if (conf > CONF_MAX) begin
                            conf = CONF_MAX;
                        end
                    end
                    res.class_id   = best_class[CLASS_ID_W-1:0];
                    res.state_code = cfg_base + best_class[BASE_W-1:0];
                    res.confidence = conf[CONF_W-1:0];
                    clear_scores();
                    awaited_results.push_back(typed ? want : res);
                end
            end
        endcase
    endfunction

    function automatic t_in_item random_item(input t_kind kind);
        logic [63:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.kind = kind;
        return it;
    endfunction

    function automatic logic signed [FEATURE_W-1:0] pick_feature();
        int near_zero;
        near_zero = $urandom_range(0, 128) - 64;
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(FEATURE_W-1){1'b1}}};
            1:       return {1'b1, {(FEATURE_W-1){1'b0}}};
            2, 3:    return near_zero[FEATURE_W-1:0];
            default: return FEATURE_W'($urandom);
        endcase
    endfunction

    function automatic t_dir_row dir_row(input t_kind kind, input int slot, input int coeff,
                                         input int fv, input bit last, input bit typed = 1'b0,
                                         input int cls = 0, input int code = 0,
                                         input int conf = 0);
        t_dir_row row;
        row.item.kind          = kind;
        row.item.slot          = SLOT_W'(slot);
        row.item.coeff         = COEFF_W'(coeff);
        row.item.feature_value = FEATURE_W'(fv);
        row.item.last_feature  = last;
        row.typed              = typed;
        row.want.class_id      = CLASS_ID_W'(cls);
        row.want.state_code    = BASE_W'(code);
        row.want.confidence    = CONF_W'(conf);
        return row;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_in_item it, input bit typed = 1'b0,
                             input t_out_item want = '0);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        score_item(it, typed, want);
        items_sent++;
        if (it.kind == KIND_NOT_READY) begin
            not_ready_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_features(input int len, input bit closed);
        t_in_item it;
        int       k;
        for (k = 0; k < len; k++) begin
            it = random_item(KIND_FEATURE);
            it.feature_value = pick_feature();
            it.last_feature  = closed && (k == len - 1);
            send_item(it);
        end
        if (closed) begin
            vectors_closed++;
        end
    endtask

    task automatic settle_idle();
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FEATURE_COUNT: cfg_features = val[FEAT_CNT_W-1:0];
            CFG_CLASS_COUNT:   cfg_classes  = val[CLASS_CNT_W-1:0];
            CFG_STATE_BASE:    cfg_base     = val[BASE_W-1:0];
            default:           ;
        endcase
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests > holds_served) begin
                holds_served++;
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                report_mismatch("class_id of a result with none awaited",
                                int'(o_out_data.class_id), -1);
            end else begin
                oldest = awaited_results.pop_front();
                if (o_out_data.class_id !== oldest.class_id) begin
                    report_mismatch("class_id", int'(o_out_data.class_id),
                                    int'(oldest.class_id));
                end
                if (o_out_data.state_code !== oldest.state_code) begin
                    report_mismatch("state_code", int'(o_out_data.state_code),
                                    int'(oldest.state_code));
                end
                if (o_out_data.confidence !== oldest.confidence) begin
                    report_mismatch("confidence", int'(o_out_data.confidence),
                                    int'(oldest.confidence));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("int8_linear_classifier_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row dir_rows [$];
        t_in_item it;
        int       p;
        int       s;
        int       pick;
        int       nf_eff;
        int       phase_end;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_FEATURE_COUNT;
        i_cfg_wdata     = '0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        not_ready_sent  = 0;
        vectors_closed  = 0;
        quiet_cycles    = 0;
        hold_requests   = 0;
        holds_served    = 0;
        calm            = 1'b0;
        cfg_features    = RESET_FEATURE_COUNT;
        cfg_classes     = RESET_CLASS_COUNT;
        cfg_base        = RESET_STATE_BASE;
        for (s = 0; s < N_CLASSES*N_FEATURES; s++) begin
            weight_mem[s] = '0;
        end
        for (s = 0; s < N_CLASSES; s++) begin
            bias_mem[s] = '0;
        end
        clear_scores();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every weight and bias is written before the first feature reads it.
        for (s = 0; s < N_CLASSES*N_FEATURES; s++) begin
            it = random_item(KIND_WEIGHT);
            it.slot = SLOT_W'(s);
            send_item(it);
        end
        for (s = 0; s < N_CLASSES; s++) begin
            it = random_item(KIND_BIAS);
            it.slot = SLOT_W'(s);
            send_item(it);
        end

        dir_rows.push_back(dir_row(KIND_NOT_READY, 0, 0, 0, 1'b0, 1'b1, 0, 0, 0));
        dir_rows.push_back(dir_row(KIND_WEIGHT, 0, -128, 0, 1'b1));
        dir_rows.push_back(dir_row(KIND_WEIGHT, 127, 127, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_WEIGHT, 16, 127, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 0, -128, 0, 1'b1));
        dir_rows.push_back(dir_row(KIND_BIAS, 7, 127, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 8, 99, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 127, -1, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, 8388607, 1'b1));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, -8388608, 1'b1));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, -1, 1'b0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, 31, 1'b0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, -8388608, 1'b0));
        dir_rows.push_back(dir_row(KIND_NOT_READY, 0, 0, 0, 1'b0, 1'b1, 0, 0, 0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, 8388607, 1'b0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, 0, 1'b1));
        // Three classes tie on bias alone: the first of them wins at full confidence.
        dir_rows.push_back(dir_row(KIND_BIAS, 1, 127, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 2, 127, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 3, 127, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, 0, 1'b1, 1'b1, 1, 1, 100));
        // All four scored classes tie at the lowest bias: class zero with no confidence.
        dir_rows.push_back(dir_row(KIND_BIAS, 1, -128, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 2, -128, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_BIAS, 3, -128, 0, 1'b0));
        dir_rows.push_back(dir_row(KIND_FEATURE, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0));
        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end

        for (p = 0; p < N_PHASES; p++) begin
            settle_idle();
            if (p < N_FIXED_PHASES) begin
                write_reg(CFG_FEATURE_COUNT, CFG_DATA_W'(PHASE_FEATURES[p]));
                write_reg(CFG_CLASS_COUNT, CFG_DATA_W'(PHASE_CLASSES[p]));
                write_reg(CFG_STATE_BASE, PHASE_BASES[p]);
            end else begin
                write_reg(CFG_FEATURE_COUNT, CFG_DATA_W'($urandom_range(0, 31)));
                write_reg(CFG_CLASS_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
                write_reg(CFG_STATE_BASE, CFG_DATA_W'($urandom));
            end
            calm = (p == N_PHASES - 1);
            if (p == 1 || p == 5) begin
                hold_requests++;
            end
            nf_eff = (cfg_features > N_FEATURES) ? N_FEATURES : int'(cfg_features);
            if (nf_eff == 0) begin
                nf_eff = 1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_features($urandom_range(N_FEATURES + 1, 40), 1'b1);
                    end else begin
                        send_features($urandom_range(1, nf_eff + 1), 1'b1);
                    end
                end else if (pick < 72) begin
                    it = random_item(KIND_WEIGHT);
                    if ($urandom_range(0, 3) == 0) begin
                        it.coeff = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
                    end
                    send_item(it);
                end else if (pick < 78) begin
                    it = random_item(KIND_BIAS);
                    it.slot = SLOT_W'($urandom_range(0, 2*N_CLASSES - 1));
                    send_item(it);
                end else if (pick < 84) begin
                    send_item(random_item(KIND_NOT_READY));
                end else if (pick < 92) begin
                    send_features($urandom_range(1, nf_eff), 1'b0);
                end else begin
                    send_item(random_item(t_kind'($urandom_range(0, 3))));
                end
            end
        end
        settle_idle();

        if (awaited_results.size() != 0) begin
            report_mismatch("results never delivered", awaited_results.size(), 0);
        end
        $display("int8_linear_classifier_tb: %0d transfers in, %0d results checked, %0d mismatches",
                 items_sent, results_checked, error_count);
        $display("int8_linear_classifier_tb: %0d register phases, %0d vectors, %0d not-ready",
                 N_PHASES, vectors_closed, not_ready_sent);
        if (error_count == 0) begin
            $display("int8_linear_classifier_tb: done, clean");
        end else begin
            $display("int8_linear_classifier_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ilc_pkg.sv
hw/rtl/ilc_coef_store.sv
hw/rtl/ilc_score_unit.sv
hw/rtl/int8_linear_classifier.sv
tb/int8_linear_classifier_tb.sv
